// File: rtl/core/b64d_pkg.sv
// b64d_pkg: shared types, constants and the symbol lookup for the base64 decoder
// no dependencies; imported by b64d_quartet, base64_strict_decoder and b64d_checker

package b64d_pkg;

    // result status carried on the result channel's tuser
    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_END  = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    // six-bit symbol value, with one extra code for a character outside the alphabet
    localparam logic [6:0] SYM_BAD  = 7'd64;
    localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

    // decoded quartet
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] count;   // bytes produced, zero when the quartet is invalid
        logic       padded;
    } quartet_t;

    // alphabet lookup: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [6:0] sym_value(input logic [7:0] ch);
        logic [7:0] v;
        v = 8'd64;
        if (ch inside {[8'h41:8'h5A]}) begin
            v = ch - 8'h41;
        end else if (ch inside {[8'h61:8'h7A]}) begin
            v = ch - 8'h47;
        end else if (ch inside {[8'h30:8'h39]}) begin
            v = ch + 8'h04;
        end else if (ch == 8'h2B) begin
            v = 8'd62;
        end else if (ch == 8'h2F) begin
            v = 8'd63;
        end
        return v[6:0];
    endfunction

endpackage

// File: rtl/core/base64_strict_decoder.sv
// base64_strict_decoder: strict base64 text decoder, one character per input transfer
// depends on b64d_pkg and b64d_quartet

// Takes one text character per input transfer (tlast marks the final character)
// and gives decoded bytes on the result channel, one result per transfer: tdata is
// the byte, tuser the status (0 byte, 1 clean end, 2 invalid input) and tlast marks
// the final result caused by one character. Whitespace is skipped. The decode of
// each character is done in the cycle it is accepted and its results (up to four)
// are held in a result register that also serves as the output register. A
// character that yields no result or one result does not hold the input, so the
// block runs at one character per cycle while the sink is ready; a character that
// completes a quartet yields up to three bytes (four with the end report) and the
// input then waits until the last of them is taken, since the result port moves
// one result per cycle and only while the sink is ready.
// After an error, characters are swallowed until the one marked last, which
// returns the block to its reset state.

module base64_strict_decoder
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] text_byte
    input  logic       s_tlast,    // end_of_text
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] data_byte
    output logic [1:0] m_tuser,    // [1:0] status
    output logic       m_tlast     // last_of_run
);

    // decoder state
    logic [7:0] sym_reg [3];
    logic [1:0] count_reg, count_next;
    logic       pad_reg, pad_next;
    logic       err_reg, err_next;

    // result register
    logic [7:0] byte_reg [3];
    logic [1:0] ndata_reg, ndata_next;
    logic       tail_reg, tail_next;
    status_t    tail_st_reg, tail_st_next;
    logic [1:0] idx_reg;

    logic       accept;
    logic       pop;
    logic       out_last;
    logic [2:0] total;
    logic       is_ws;
    logic       store_wr;
    logic       err;
    quartet_t   quartet;

    b64d_quartet u_quartet (
        .sym0    (sym_reg[0]),
        .sym1    (sym_reg[1]),
        .sym2    (sym_reg[2]),
        .sym3    (s_tdata),
        .quartet (quartet)
    );

    // result channel handshake
    assign total    = {1'b0, ndata_reg} + {2'b00, tail_reg};
    assign m_tvalid = (total != 3'd0);
    assign out_last = (({1'b0, idx_reg} + 3'd1) == total);
    assign pop      = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || (pop && out_last);
    assign accept   = s_tvalid && s_tready;
    assign m_tlast  = out_last;

    // current result
    always_comb begin
        m_tdata = 8'd0;
        m_tuser = ST_DATA;
        if ({1'b0, idx_reg} >= {1'b0, ndata_reg}) begin
            m_tuser = tail_st_reg;
        end else begin
            case (idx_reg)
                2'd0:    m_tdata = byte_reg[0];
                2'd1:    m_tdata = byte_reg[1];
                2'd2:    m_tdata = byte_reg[2];
                default: m_tdata = 8'd0;
            endcase
        end
    end

    // per-character decode: next state and the results it causes
    always_comb begin
        is_ws        = s_tdata inside {8'h0A, 8'h0D, 8'h09, 8'h20};
        count_next   = count_reg;
        pad_next     = pad_reg;
        err_next     = err_reg;
        ndata_next   = 2'd0;
        tail_next    = 1'b0;
        tail_st_next = ST_END;
        store_wr     = 1'b0;
        err          = 1'b0;
        if (err_reg) begin
            if (s_tlast) begin
                count_next = 2'd0;
                pad_next   = 1'b0;
                err_next   = 1'b0;
            end
        end else begin
            if (!is_ws) begin
                if (pad_reg) begin
                    err = 1'b1;
                end else if (count_reg != 2'd3) begin
                    store_wr   = 1'b1;
                    count_next = count_reg + 2'd1;
                end else begin
                    count_next = 2'd0;
                    if (quartet.count == 2'd0) begin
                        err = 1'b1;
                    end else begin
                        ndata_next = quartet.count;
                        pad_next   = pad_reg | quartet.padded;
                    end
                end
            end
            if (err) begin
                ndata_next   = 2'd0;
                tail_next    = 1'b1;
                tail_st_next = ST_ERR;
                if (s_tlast) begin
                    count_next = 2'd0;
                    pad_next   = 1'b0;
                end else begin
                    err_next = 1'b1;
                end
            end else if (s_tlast) begin
                tail_next    = 1'b1;
                tail_st_next = (count_next != 2'd0) ? ST_ERR : ST_END;
                count_next   = 2'd0;
                pad_next     = 1'b0;
                err_next     = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= 2'd0;
            pad_reg     <= 1'b0;
            err_reg     <= 1'b0;
            ndata_reg   <= 2'd0;
            tail_reg    <= 1'b0;
            tail_st_reg <= ST_END;
            idx_reg     <= 2'd0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                pad_reg     <= pad_next;
                err_reg     <= err_next;
                ndata_reg   <= ndata_next;
                tail_reg    <= tail_next;
                tail_st_reg <= tail_st_next;
                idx_reg     <= 2'd0;
            end else if (pop) begin
                if (out_last) begin
                    ndata_reg <= 2'd0;
                    tail_reg  <= 1'b0;
                    idx_reg   <= 2'd0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    // symbol store and decoded bytes
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (store_wr && count_reg == 2'd0) sym_reg[0] <= s_tdata;
            if (store_wr && count_reg == 2'd1) sym_reg[1] <= s_tdata;
            if (store_wr && count_reg == 2'd2) sym_reg[2] <= s_tdata;
            byte_reg[0] <= quartet.byte0;
            byte_reg[1] <= quartet.byte1;
            byte_reg[2] <= quartet.byte2;
        end
    end

endmodule

// File: rtl/core/b64d_quartet.sv
// b64d_quartet: checks four gathered symbols and decodes them into up to three bytes
// depends on b64d_pkg (sym_value, quartet_t)

module b64d_quartet
    import b64d_pkg::*;
(
    input  logic [7:0] sym0,
    input  logic [7:0] sym1,
    input  logic [7:0] sym2,
    input  logic [7:0] sym3,
    output quartet_t   quartet
);

    logic [6:0]  v0;
    logic [6:0]  v1;
    logic [6:0]  v2;
    logic [6:0]  v3;
    logic        p2;
    logic        p3;
    logic [23:0] bits;

    // symbol values, padding counts as zero bits
    always_comb begin
        p2   = (sym2 == PAD_CHAR);
        p3   = (sym3 == PAD_CHAR);
        v0   = sym_value(sym0);
        v1   = sym_value(sym1);
        v2   = p2 ? 7'd0 : sym_value(sym2);
        v3   = p3 ? 7'd0 : sym_value(sym3);
        bits = {v0[5:0], v1[5:0], v2[5:0], v3[5:0]};
    end

    // validity, padding placement and unused trailing bits
    always_comb begin
        quartet.byte0  = bits[23:16];
        quartet.byte1  = bits[15:8];
        quartet.byte2  = bits[7:0];
        quartet.padded = p2 || p3;
        if (v0 == SYM_BAD || v1 == SYM_BAD) begin
            quartet.count = 2'd0;
        end else if (p2 && !p3) begin
            quartet.count = 2'd0;
        end else if (v2 == SYM_BAD || v3 == SYM_BAD) begin
            quartet.count = 2'd0;
        end else if (p2) begin
            quartet.count = (v1[3:0] != 4'd0) ? 2'd0 : 2'd1;
        end else if (p3) begin
            quartet.count = (v2[1:0] != 2'd0) ? 2'd0 : 2'd2;
        end else begin
            quartet.count = 2'd3;
        end
    end

endmodule

// File: rtl/core/b64d_checker.sv
// b64d_checker: port-level assertions for base64_strict_decoder, bound to the top level
// depends on b64d_pkg (status codes)

module b64d_checker
    import b64d_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // result register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // end and error reports close a run
    a_tail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DATA |-> m_tlast && m_tdata == 8'd0)
        else $error("status report not last or carries data");

    // no new character while a run still has results pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a run");

endmodule

bind base64_strict_decoder b64d_checker u_b64d_checker (.*);

// File: sim/tb_top.sv
// tb_top: self-checking bench for base64_strict_decoder, directed text then random frames
// with stalls on both channels; results are checked against an in-bench decode model
// depends on b64d_pkg and base64_strict_decoder

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam int TEXT_CHARS   = 180;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 20;

    // one expected transfer on the result channel
    typedef struct {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } decode_result_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // decode model plus queue of results still to come out of the block
    class decode_scoreboard;
        decode_result_t decoded_q[$];
        logic [7:0]     held_sym[3];
        logic [1:0]     held_cnt;
        logic           pad_done;
        logic           err_latched;
        int             errors;
        int             live_chars;

        function new();
            errors = 0;
            live_chars = 0;
            restart();
        endfunction

        function void restart();
            held_cnt = 2'd0;
            pad_done = 1'b0;
            err_latched = 1'b0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        // 6-bit alphabet index, or SYM_BAD for anything outside it
        function logic [6:0] alpha_index(logic [7:0] ch);
            if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
            if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 26);
            if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 52);
            if (ch == "+") return 7'd62;
            if (ch == "/") return 7'd63;
            return SYM_BAD;
        endfunction

        function void push_result(ref decode_result_t batch[$], input logic [7:0] data,
                                  input status_t status);
            decode_result_t r;
            r.data = data;
            r.status = status;
            r.last = 1'b0;
            batch.push_back(r);
        endfunction

        // note one accepted character and queue the results it causes
        function void decode_char(logic [7:0] ch, logic eot);
            decode_result_t batch[$];
            logic       is_ws, fail, p2, p3;
            logic [6:0] v0, v1, v2, v3;
            logic [23:0] word;
            int         nbytes;

            // every accepted character counts toward the run length
            live_chars++;
            // after an error everything is swallowed until end of text
            if (err_latched) begin
                if (eot) restart();
                return;
            end
            is_ws = (ch == CH_LF || ch == CH_CR || ch == CH_TAB || ch == CH_SP);
            fail = 1'b0;

            if (!is_ws) begin
                if (pad_done) begin
                    fail = 1'b1;
                end else if (held_cnt < 2'd3) begin
                    held_sym[held_cnt] = ch;
                    held_cnt++;
                end else begin
                    // fourth symbol: decode the quartet
                    held_cnt = 2'd0;
                    v0 = alpha_index(held_sym[0]);
                    v1 = alpha_index(held_sym[1]);
                    p2 = (held_sym[2] == PAD_CHAR);
                    p3 = (ch == PAD_CHAR);
                    v2 = p2 ? 7'd0 : alpha_index(held_sym[2]);
                    v3 = p3 ? 7'd0 : alpha_index(ch);
                    word = {v0[5:0], v1[5:0], v2[5:0], v3[5:0]};
                    if (v0 == SYM_BAD || v1 == SYM_BAD || (p2 && !p3) ||
                        v2 == SYM_BAD || v3 == SYM_BAD) begin
                        nbytes = 0;
                    end else if (p2) begin
                        nbytes = (v1[3:0] != 4'd0) ? 0 : 1;
                    end else if (p3) begin
                        nbytes = (v2[1:0] != 2'd0) ? 0 : 2;
                    end else begin
                        nbytes = 3;
                    end
                    if (nbytes == 0) begin
                        fail = 1'b1;
                    end else begin
                        push_result(batch, word[23:16], ST_DATA);
                        if (nbytes > 1) push_result(batch, word[15:8], ST_DATA);
                        if (nbytes > 2) push_result(batch, word[7:0], ST_DATA);
                        if (p2 || p3) pad_done = 1'b1;
                    end
                end
            end

            // error report, or end report after any bytes of this character
            if (fail) begin
                batch.delete();
                push_result(batch, 8'h00, ST_ERR);
                if (eot) restart();
                else err_latched = 1'b1;
            end else if (eot) begin
                push_result(batch, 8'h00, (held_cnt != 2'd0) ? ST_ERR : ST_END);
                restart();
            end

            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) decoded_q.push_back(batch[i]);
        endfunction

        // compare one result transfer with the oldest expectation
        function void compare_output(logic [7:0] data, logic [1:0] status, logic last);
            decode_result_t want;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, got data=%h status=%0d last=%b",
                         $time, data, status, last);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (data !== want.data) begin
                $display("%0t: data mismatch: expected %h, got %h",
                         $time, want.data, data);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, status);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch: expected %b, got %b",
                         $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    decode_scoreboard sb = new();
    logic [7:0] frame_q[$];
    int         burst_left = 0;
    logic       gaps_on = 1'b1;
    int         quiet_cycles = 0;
    int         rx_cycle = 0;
    rx_mode_t   rx_mode = RX_OPEN;

    base64_strict_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // receiver stall pattern in one of four randomly chosen modes
    always @(negedge aclk) begin
        if (rx_cycle % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= ((rx_cycle % 5) < 2);
        endcase
    end

    // result monitor and stall watchdog
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.compare_output(m_tdata, m_tuser, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [7:0] b64_symbol(logic [5:0] idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0:       return CH_LF;
            1:       return CH_CR;
            2:       return CH_TAB;
            default: return CH_SP;
        endcase
    endfunction

    // append a symbol, sometimes preceded by whitespace
    function automatic void add_symbol(logic [7:0] ch, logic ws_on);
        if (ws_on && $urandom_range(0, 5) == 0) frame_q.push_back(ws_char());
        frame_q.push_back(ch);
    endfunction

    // one input transfer, called and returning at a falling edge
    task automatic push_char(input logic [7:0] ch, input logic eot);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                gap = $urandom_range(1, 5);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.decode_char(ch, eot);
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt, input logic eot);
        for (int i = 0; i < txt.len(); i++) push_char(txt[i], eot && (i == txt.len() - 1));
    endtask

    // hold the input until every queued result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // one random frame: mostly valid base64, some damaged, some noise
    task automatic send_random_frame();
        logic [7:0]  raw[$];
        logic [23:0] word;
        logic        ws_on;
        int          kind, n, rem, pos;

        frame_q.delete();
        gaps_on = ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 99);
        if (kind < 90) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 7);
            ws_on = ($urandom_range(0, 2) == 0);
            raw.delete();
            for (int i = 0; i < n; i++) raw.push_back(8'($urandom_range(0, 255)));
            for (int i = 0; i < n; i += 3) begin
                rem = n - i;
                word = {raw[i], (rem > 1) ? raw[i + 1] : 8'h00, (rem > 2) ? raw[i + 2] : 8'h00};
                add_symbol(b64_symbol(word[23:18]), ws_on);
                add_symbol(b64_symbol(word[17:12]), ws_on);
                add_symbol((rem > 1) ? b64_symbol(word[11:6]) : PAD_CHAR, ws_on);
                add_symbol((rem > 2) ? b64_symbol(word[5:0]) : PAD_CHAR, ws_on);
            end
            // damage a valid frame
            if (kind >= 70) begin
                pos = (frame_q.size() > 0) ? $urandom_range(0, frame_q.size() - 1) : 0;
                case ($urandom_range(0, 4))
                    0: if (frame_q.size() > 0) frame_q[pos] = 8'($urandom_range(0, 255));
                    1: if (frame_q.size() > 0) frame_q.delete(pos);
                    2: frame_q.insert($urandom_range(0, frame_q.size()), PAD_CHAR);
                    3: frame_q.push_back(b64_symbol(6'($urandom_range(0, 63))));
                    default: if (frame_q.size() > 0)
                        frame_q[pos] = b64_symbol(6'($urandom_range(0, 63)));
                endcase
            end
        end else begin
            // noise: raw bytes mixed with symbols, padding and whitespace
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0:       frame_q.push_back(8'($urandom_range(0, 255)));
                    1:       frame_q.push_back(PAD_CHAR);
                    2:       frame_q.push_back(ws_char());
                    default: frame_q.push_back(b64_symbol(6'($urandom_range(0, 63))));
                endcase
            end
        end
        if (frame_q.size() == 0 || $urandom_range(0, 5) == 0) frame_q.push_back(ws_char());
        foreach (frame_q[i]) push_char(frame_q[i], i == frame_q.size() - 1);
        if ($urandom_range(0, 9) == 0) drain_results();
    endtask

    // reset, directed text, random frames, then wait out the results
    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full quartet on the last character: three bytes then end report
        send_text("TWFu", 1'b1);
        // padded quartet with all four whitespace kinds, whitespace closes the text
        push_char(CH_LF, 1'b0);
        send_text("TQ", 1'b0);
        push_char(CH_CR, 1'b0);
        send_text("==", 1'b0);
        push_char(CH_TAB, 1'b0);
        push_char(CH_SP, 1'b1);
        // symbol after a padded quartet, error on the last character
        send_text("TWE=A", 1'b1);
        // nonzero unused bits, then a swallowed character closes the text
        send_text("TR==", 1'b0);
        push_char(8'hFF, 1'b1);
        // pad in the third place without one in the fourth
        send_text("AB=C", 1'b1);
        // partial quartet at end of text
        send_text("Zm", 1'b1);
        drain_results();

        // random frames until the whole run reaches its character count
        while (sb.live_chars < TEXT_CHARS) send_random_frame();

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
